[src/dcsa_pkg.sv]
// Shared types, constants and helpers for the contact score accumulator.
// Used by the divider and the top level; depends on nothing else.
package dcsa_pkg;

  localparam int unsigned MaxAligned = 1024;
  localparam int unsigned CountW     = 11;
  localparam int unsigned DistW      = 16;
  localparam int unsigned ScoreW     = 40;

  // Divider widths: numerator is left-aligned in a 42-bit word.
  localparam int unsigned DivNumW  = 42;
  localparam int unsigned DivDenW  = 32;
  localparam int unsigned DivCntW  = 6;

  // Far-pair limit on the distance sum (50 angstrom mean, 1/128 units).
  localparam logic [16:0] FarLimit = 17'd12800;
  // Exponent clamp: t above 2^20 gives a zero weight.
  localparam logic [41:0] ExpLimit = 42'd1048576;
  // log2(e) in Q.16 and ln(2) in Q.32.
  localparam logic [16:0] Log2eQ16 = 17'd94548;
  localparam logic [31:0] Ln2Q32   = 32'd2977044472;

  localparam logic signed [ScoreW-1:0] SumMax = {1'b0, {(ScoreW-1){1'b1}}};
  localparam logic signed [ScoreW-1:0] SumMin = {1'b1, {(ScoreW-1){1'b0}}};

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_DIAG_WEIGHT = 3'd0,
    REG_HORIZON     = 3'd1,
    REG_CUT_ENABLE  = 3'd2,
    REG_CUTOFF      = 3'd3,
    REG_FILTER_MODE = 3'd4
  } cfg_reg_e;

  // Filter modes.
  localparam logic [1:0] ModeFirst  = 2'd0;
  localparam logic [1:0] ModeBoth   = 2'd1;
  localparam logic [1:0] ModeEither = 2'd2;

  // Request to the shared divider.
  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
    logic [DivCntW-1:0] nbits;
  } div_req_t;

  // Answer from the shared divider.
  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DivNumW-1:0] quo;
  } div_rsp_t;

  // Saturate a widened sum to the 40-bit score range.
  function automatic logic signed [ScoreW-1:0] sat_score(logic signed [ScoreW+1:0] x);
    logic signed [ScoreW-1:0] res;
    if (x > $signed({{2{SumMax[ScoreW-1]}}, SumMax})) begin
      res = SumMax;
    end else if (x < $signed({{2{SumMin[ScoreW-1]}}, SumMin})) begin
      res = SumMin;
    end else begin
      res = x[ScoreW-1:0];
    end
    return res;
  endfunction

endpackage

[src/dali_contact_score_accumulator.sv]
// Contact score accumulator: top level with sequencer and datapath.
// Depends on dcsa_pkg and instantiates the shared divider dcsa_div.
//
// The block takes one distance pair per transaction and is not ready while it
// works on it. A pair that is filtered out, marked absent, far apart (mean
// above 50 angstrom) or seen with a zero horizon goes from accept through
// set-up straight to close. A scored pair is set by a single shared divider
// that makes one quotient bit per cycle: it divides for the diff/mean ratio
// (31 bits), for the gaussian exponent (42 bits) and for each of the ten
// series terms of the exponential (33 bits, each after a multiply); around
// these the sequencer accepts, sets up, splits the exponent, forms the weight,
// multiplies, accumulates and closes. A zero mean skips the ratio; an exponent
// past the clamp skips the series and gives a zero weight. A last transaction
// loads the score into an output register; the next input transaction is
// taken while that score waits, and a later last transaction stalls only if
// the previous score has still not been taken.
module dali_contact_score_accumulator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port.
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_idx_i,
  input  logic [15:0]                  cfg_wdata_i,
  // Input channel.
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [dcsa_pkg::DistW-1:0]   d_first_i,
  input  logic [dcsa_pkg::DistW-1:0]   d_second_i,
  input  logic                         has_pair_i,
  input  logic                         last_i,
  input  logic [dcsa_pkg::CountW-1:0]  aligned_count_i,
  // Output channel.
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [dcsa_pkg::ScoreW-1:0] score_o
);
  import dcsa_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_PREP  = 15'b000000000000010,
    S_RGO   = 15'b000000000000100,
    S_RWAIT = 15'b000000000001000,
    S_TGO   = 15'b000000000010000,
    S_TWAIT = 15'b000000000100000,
    S_EXPU  = 15'b000000001000000,
    S_EXPZ  = 15'b000000010000000,
    S_SMUL  = 15'b000000100000000,
    S_SGO   = 15'b000001000000000,
    S_SWAIT = 15'b000010000000000,
    S_WGT   = 15'b000100000000000,
    S_PROD  = 15'b001000000000000,
    S_ACC   = 15'b010000000000000,
    S_FIN   = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [15:0] diag_w_q, horizon_q, cutoff_q;
  logic        cut_en_q;
  logic [1:0]  mode_q;

  // Latched transaction.
  logic [DistW-1:0]  d1_q, d2_q;
  logic              has_pair_q, last_q;
  logic [CountW-1:0] count_q;

  // Datapath registers.
  logic [13:0]             s_q, s_d;
  logic [13:0]             diff_q, diff_d;
  logic [27:0]             sq_q, sq_d;
  logic [31:0]             h2_q, h2_d;
  logic [17:0]             r_q, r_d;
  logic [20:0]             t_q, t_d;
  logic [4:0]              n_q, n_d;
  logic [15:0]             f_q, f_d;
  logic [31:0]             z_q, z_d;
  logic [32:0]             a_q, a_d;
  logic [34:0]             e_q, e_d;
  logic [3:0]              k_q, k_d;
  logic [16:0]             w_q, w_d;
  logic signed [36:0]      p_q, p_d;
  logic signed [ScoreW-1:0] sum_q, sum_d;
  logic signed [ScoreW-1:0] score_q, score_d;
  logic                    out_valid_q, out_valid_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Combinational helpers.
  logic [16:0]        s_full;
  logic [15:0]        diff_full;
  logic               near1, near2, kept, skip;
  logic [37:0]        u_full;
  logic [47:0]        z_full;
  logic [64:0]        az_full;
  logic [32:0]        a_new;
  logic [35:0]        e_bias;
  logic [35:0]        e_shift;
  logic signed [18:0] term;
  logic signed [36:0] p_mag;
  logic signed [21:0] contrib;
  logic [CountW-1:0]  cnt_sat;
  logic [26:0]        col_sum;
  logic               out_free;

  dcsa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diag_w_q  <= 16'd13107;
      horizon_q <= 16'd1280;
      cut_en_q  <= 1'b0;
      cutoff_q  <= 16'd0;
      mode_q    <= ModeFirst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_DIAG_WEIGHT: diag_w_q  <= cfg_wdata_i;
        REG_HORIZON:     horizon_q <= cfg_wdata_i;
        REG_CUT_ENABLE:  cut_en_q  <= cfg_wdata_i[0];
        REG_CUTOFF:      cutoff_q  <= cfg_wdata_i;
        REG_FILTER_MODE: mode_q    <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // Pair screening.
  always_comb begin
    s_full    = {1'b0, d1_q} + {1'b0, d2_q};
    diff_full = (d1_q > d2_q) ? (d1_q - d2_q) : (d2_q - d1_q);
    near1     = d1_q <= cutoff_q;
    near2     = d2_q <= cutoff_q;
    case (mode_q)
      ModeBoth:   kept = near1 && near2;
      ModeEither: kept = near1 || near2;
      default:    kept = near1;
    endcase
    if (!cut_en_q) begin
      kept = 1'b1;
    end
    skip = !has_pair_q || !kept || (s_full > FarLimit) || (horizon_q == 16'd0);
  end

  // Arithmetic of the single steps.
  always_comb begin
    u_full  = 38'(t_q) * 38'(Log2eQ16);
    z_full  = 48'(f_q) * 48'(Ln2Q32);
    az_full = 65'(a_q) * 65'(z_q);
    a_new   = div_rsp.quo[32:0];
    e_bias  = {1'b0, e_q} + (36'd1 << (6'd15 + 6'(n_q)));
    e_shift = e_bias >> (6'd16 + 6'(n_q));
    term    = $signed({3'b000, diag_w_q}) - $signed({1'b0, r_q});
    p_mag   = -p_q;
    if (p_q >= 0) begin
      contrib = 22'((p_q + 37'sd32768) >>> 16);
    end else begin
      contrib = -$signed(22'((p_mag + 37'sd32767) >>> 16));
    end
    cnt_sat = (count_q > CountW'(MaxAligned)) ? CountW'(MaxAligned) : count_q;
    col_sum = 27'(cnt_sat) * 27'(diag_w_q);
  end

  assign out_free = !out_valid_q || out_ready_i;

  // Sequencer and datapath next state.
  always_comb begin
    state_d     = state_q;
    s_d         = s_q;
    diff_d      = diff_q;
    sq_d        = sq_q;
    h2_d        = h2_q;
    r_d         = r_q;
    t_d         = t_q;
    n_d         = n_q;
    f_d         = f_q;
    z_d         = z_q;
    a_d         = a_q;
    e_d         = e_q;
    k_d         = k_q;
    w_d         = w_q;
    p_d         = p_q;
    sum_d       = sum_q;
    score_d     = score_q;
    out_valid_d = out_valid_q && !out_ready_i;
    div_req     = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        s_d    = s_full[13:0];
        diff_d = diff_full[13:0];
        sq_d   = 28'(s_full[13:0]) * 28'(s_full[13:0]);
        h2_d   = 32'(horizon_q) * 32'(horizon_q);
        if (skip) begin
          state_d = S_FIN;
        end else if (s_full == 17'd0) begin
          r_d     = '0;
          state_d = S_TGO;
        end else begin
          state_d = S_RGO;
        end
      end
      // Ratio diff * 2^17 / s, numerator of 31 bits left-aligned.
      S_RGO: begin
        div_req.start = 1'b1;
        div_req.num   = {diff_q, 28'd0};
        div_req.den   = 32'(s_q);
        div_req.nbits = DivCntW'(31);
        state_d       = S_RWAIT;
      end
      S_RWAIT: begin
        if (div_rsp.done) begin
          r_d     = div_rsp.quo[17:0];
          state_d = S_TGO;
        end
      end
      // Exponent s^2 * 2^14 / horizon^2.
      S_TGO: begin
        div_req.start = 1'b1;
        div_req.num   = {sq_q, 14'd0};
        div_req.den   = h2_q;
        div_req.nbits = DivCntW'(42);
        state_d       = S_TWAIT;
      end
      S_TWAIT: begin
        if (div_rsp.done) begin
          if (div_rsp.quo > ExpLimit) begin
            w_d     = '0;
            state_d = S_PROD;
          end else begin
            t_d     = div_rsp.quo[20:0];
            state_d = S_EXPU;
          end
        end
      end
      // Split t*log2(e) into integer and fraction.
      S_EXPU: begin
        n_d = u_full[36:32];
        f_d = u_full[31:16];
        if (u_full[37:32] > 6'd16) begin
          w_d     = '0;
          state_d = S_PROD;
        end else begin
          state_d = S_EXPZ;
        end
      end
      S_EXPZ: begin
        z_d     = z_full[47:16];
        a_d     = 33'd1 << 32;
        e_d     = 35'd1 << 32;
        k_d     = 4'd1;
        state_d = S_SMUL;
      end
      // Series term: a = floor(a*z / 2^32) / k.
      S_SMUL: begin
        a_d     = az_full[64:32];
        state_d = S_SGO;
      end
      S_SGO: begin
        div_req.start = 1'b1;
        div_req.num   = {a_q, 9'd0};
        div_req.den   = 32'(k_q);
        div_req.nbits = DivCntW'(33);
        state_d       = S_SWAIT;
      end
      S_SWAIT: begin
        if (div_rsp.done) begin
          a_d = a_new;
          e_d = k_q[0] ? (e_q - 35'(a_new)) : (e_q + 35'(a_new));
          if (k_q == 4'd10) begin
            state_d = S_WGT;
          end else begin
            k_d     = k_q + 4'd1;
            state_d = S_SMUL;
          end
        end
      end
      S_WGT: begin
        w_d     = e_shift[16:0];
        state_d = S_PROD;
      end
      S_PROD: begin
        p_d     = $signed({20'd0, w_q}) * 37'(term);
        state_d = S_ACC;
      end
      S_ACC: begin
        sum_d   = sat_score(42'(sum_q) + 42'(contrib));
        state_d = S_FIN;
      end
      // Close the transaction; a last one loads the score register.
      S_FIN: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          if (count_q == '0) begin
            score_d = '0;
          end else begin
            score_d = sat_score(42'(sum_q) + $signed({15'd0, col_sum}));
          end
          out_valid_d = 1'b1;
          sum_d       = '0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      sum_q       <= sum_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      d1_q       <= d_first_i;
      d2_q       <= d_second_i;
      has_pair_q <= has_pair_i;
      last_q     <= last_i;
      count_q    <= aligned_count_i;
    end
    s_q     <= s_d;
    diff_q  <= diff_d;
    sq_q    <= sq_d;
    h2_q    <= h2_d;
    r_q     <= r_d;
    t_q     <= t_d;
    n_q     <= n_d;
    f_q     <= f_d;
    z_q     <= z_d;
    a_q     <= a_d;
    e_q     <= e_d;
    k_q     <= k_d;
    w_q     <= w_d;
    p_q     <= p_d;
    score_q <= score_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign score_o     = score_q;

endmodule

[src/dcsa_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on dcsa_pkg for the request and answer structs.
module dcsa_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dcsa_pkg::div_req_t  req_i,
  output dcsa_pkg::div_rsp_t  rsp_o
);
  import dcsa_pkg::*;

  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivNumW-1:0] num_q, num_d;
  logic [DivNumW-1:0] quo_q, quo_d;
  logic [DivDenW-1:0] rem_q, rem_d;
  logic [DivDenW-1:0] den_q, den_d;
  logic [DivDenW:0]   trial;
  logic               fits;

  // One step: shift in the next numerator bit and try the subtraction.
  assign trial = {rem_q, num_q[DivNumW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      cnt_d  = req_i.nbits;
      busy_d = 1'b1;
      num_d  = req_i.num;
      quo_d  = '0;
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      num_d = {num_q[DivNumW-2:0], 1'b0};
      quo_d = {quo_q[DivNumW-2:0], fits};
      rem_d = fits ? DivDenW'(trial - {1'b0, den_q}) : trial[DivDenW-1:0];
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

[src/dcsa_checker.sv]
// Port-level checks for the contact score accumulator, bound to the top level.
// Depends on dcsa_pkg for the score width.
module dcsa_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               last_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [dcsa_pkg::ScoreW-1:0] score_o
);
  import dcsa_pkg::*;

  // A waiting score holds, unchanged, until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(score_o))
    else $error("score changed or dropped while stalled");

  // The block works on one transaction at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an accepted transaction");

  // A score never appears in the cycle right after an accepted transaction.
  a_no_early_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("score raised too early");

  // A non-last transaction alone cannot raise a score as its set-up state closes.
  a_not_last_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !last_i |=> ##1 !$rose(out_valid_o))
    else $error("score raised by a transaction that was not last");

endmodule

bind dali_contact_score_accumulator dcsa_checker u_dcsa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .last_i      (last_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .score_o     (score_o)
);

[bench/tb_dali_contact_score_accumulator.sv]
// Testbench for the contact score accumulator: directed table, then random alignments.
// Depends on dcsa_pkg and dali_contact_score_accumulator; scores are predicted in the bench.
module tb_dali_contact_score_accumulator;
  timeunit 1ns;
  timeprecision 1ps;
  import dcsa_pkg::*;

  localparam longint CycleLimit = 4000000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  cfg_reg_e cfg_idx;
  logic [15:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  logic [DistW-1:0] d_first_i;
  logic [DistW-1:0] d_second_i;
  logic has_pair_i;
  logic last_i;
  logic [CountW-1:0] aligned_count_i;
  logic out_valid_o;
  logic out_ready_i;
  logic signed [ScoreW-1:0] score_o;

  dali_contact_score_accumulator u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i(cfg_idx), .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .d_first_i, .d_second_i, .has_pair_i, .last_i,
    .aligned_count_i, .out_valid_o, .out_ready_i, .score_o
  );

  // One pair transaction.
  typedef struct {
    logic [15:0] d1;
    logic [15:0] d2;
    logic        has;
    logic        lst;
    logic [10:0] cnt;
  } pair_t;

  // Directed row: an expected score is typed in where known, else predicted.
  typedef struct {
    pair_t p;
    bit    known;
    longint score;
  } row_t;

  // Bench copy of the configuration and running sum.
  logic [15:0] diag_w, horiz, cutoff;
  logic        cut_en;
  logic [1:0]  fmode;
  longint      run_sum;

  logic signed [ScoreW-1:0] score_q[$];
  int  errors;
  int  n_scores;
  longint cycles;
  bit  no_idle;
  bit  hold_in;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Cycle counter with run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic longint sat40(longint x);
    if (x > 64'sd549755813887) return 64'sd549755813887;
    if (x < -64'sd549755813888) return -64'sd549755813888;
    return x;
  endfunction

  // Gaussian weight exp(-t), t in Q.16, result in Q.16.
  function automatic longint gauss_weight(longint unsigned t);
    longint unsigned u, f, z, e, a;
    int n;
    if (t > 64'd1048576) return 0;
    u = (t * 94548) >> 16;
    n = int'(u >> 16);
    if (n > 16) return 0;
    f = u & 64'hFFFF;
    z = (f * 64'd2977044472) >> 16;
    a = 64'd1 << 32;
    e = a;
    for (int k = 1; k <= 10; k++) begin
      a = ((a * z) >> 32) / k;
      if (k % 2 == 1) e = e - a;
      else e = e + a;
    end
    return longint'((e + (64'd1 << (15 + n))) >> (16 + n));
  endfunction

  function automatic longint pair_gain(logic [15:0] d1, logic [15:0] d2);
    longint unsigned s, diff, r, t;
    longint w, p;
    s = longint'(d1) + longint'(d2);
    diff = (d1 > d2) ? d1 - d2 : d2 - d1;
    r = 0;
    if (s > 12800 || horiz == 0) return 0;
    if (s != 0) r = (diff * 131072) / s;
    t = (s * s * 16384) / (longint'(horiz) * longint'(horiz));
    w = gauss_weight(t);
    p = w * (longint'(diag_w) - longint'(r));
    if (p >= 0) return (p + 32768) >>> 16;
    return -((-p + 32767) >>> 16);
  endfunction

  function automatic bit pair_kept(logic [15:0] d1, logic [15:0] d2);
    bit a, b;
    a = d1 <= cutoff;
    b = d2 <= cutoff;
    if (!cut_en) return 1;
    if (fmode == ModeBoth) return a && b;
    if (fmode == ModeEither) return a || b;
    return a;
  endfunction

  // Advance the predicted sum; returns 1 and the score when one is emitted.
  function automatic bit predict_score(pair_t p, output longint score);
    longint c;
    score = 0;
    if (p.has && pair_kept(p.d1, p.d2)) run_sum = sat40(run_sum + pair_gain(p.d1, p.d2));
    if (!p.lst) return 0;
    c = (p.cnt > MaxAligned) ? MaxAligned : p.cnt;
    score = (c == 0) ? 0 : sat40(run_sum + c * longint'(diag_w));
    run_sum = 0;
    return 1;
  endfunction

  // Drive one register write for a cycle; the caller drops the enable.
  task automatic write_reg(cfg_reg_e idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    case (idx)
      REG_DIAG_WEIGHT: diag_w = val;
      REG_HORIZON:     horiz = val;
      REG_CUT_ENABLE:  cut_en = val[0];
      REG_CUTOFF:      cutoff = val;
      default:         fmode = val[1:0];
    endcase
  endtask

  // Wait for outstanding scores plus the slowest pair's work, then reconfigure.
  task automatic settle();
    while (score_q.size() != 0) @(negedge clk_i);
    repeat (500) @(negedge clk_i);
  endtask

  task automatic set_config(logic [15:0] dw, logic [15:0] hz, logic ce,
                            logic [15:0] co, logic [1:0] fm);
    settle();
    write_reg(REG_DIAG_WEIGHT, dw);
    write_reg(REG_HORIZON, hz);
    write_reg(REG_CUT_ENABLE, {15'd0, ce});
    write_reg(REG_CUTOFF, co);
    write_reg(REG_FILTER_MODE, {14'd0, fm});
    cfg_we_i <= 1'b0;
  endtask

  // Send one transaction; optionally check against a typed-in score.
  // The block stays busy through its set-up and close states after an accept,
  // so the leading falling edge costs no throughput.
  task automatic send_pair(pair_t p, bit known, longint kscore);
    longint sc;
    @(negedge clk_i);
    while (!no_idle && !hold_in && $urandom_range(99) < 36) @(negedge clk_i);
    in_valid_i <= 1'b1;
    d_first_i <= p.d1;
    d_second_i <= p.d2;
    has_pair_i <= p.has;
    last_i <= p.lst;
    aligned_count_i <= p.cnt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (predict_score(p, sc)) begin
      if (known && sc != kscore) begin
        $error("typed-in score %0d disagrees with prediction %0d", kscore, sc);
        errors++;
      end
      score_q.push_back(ScoreW'(known ? kscore : sc));
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Output side: random stall and check against the oldest expected score.
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= no_idle || ($urandom_range(99) >= 36);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_scores++;
      if (score_q.size() == 0) begin
        $error("score %0d arrived with none expected", score_o);
        errors++;
      end else begin
        if (score_o !== score_q[0]) begin
          $error("score mismatch: expected %0d, actual %0d", score_q[0], score_o);
          errors++;
        end
        void'(score_q.pop_front());
      end
    end
  end

  function automatic pair_t mk(int d1, int d2, bit has, bit lst, int cnt);
    pair_t p;
    p.d1 = 16'(d1); p.d2 = 16'(d2); p.has = has; p.lst = lst; p.cnt = 11'(cnt);
    return p;
  endfunction

  // Random pair, mostly within scoring range, some far or extreme.
  function automatic pair_t rand_pair(bit lst);
    pair_t p;
    int sel;
    sel = $urandom_range(9);
    if (sel < 6) begin
      p.d1 = 16'($urandom_range(6400));
      p.d2 = 16'($urandom_range(6400));
    end else if (sel < 8) begin
      p.d1 = 16'($urandom_range(1500));
      p.d2 = 16'(p.d1 + $urandom_range(40));
    end else begin
      p.d1 = 16'($urandom());
      p.d2 = 16'($urandom());
    end
    p.has = ($urandom_range(9) != 0);
    p.lst = lst;
    p.cnt = ($urandom_range(7) == 0) ? 11'($urandom_range(2047)) : 11'($urandom_range(1024));
    return p;
  endfunction

  row_t dir_rows[$];

  initial begin
    errors = 0; n_scores = 0; cycles = 0; no_idle = 0; hold_in = 0;
    run_sum = 0;
    diag_w = 16'd13107; horiz = 16'd1280; cut_en = 0; cutoff = 0; fmode = ModeFirst;
    rst_ni = 1'b0; cfg_we_i = 1'b0; cfg_idx = REG_DIAG_WEIGHT; cfg_wdata_i = '0;
    in_valid_i = 1'b0; d_first_i = '0; d_second_i = '0; has_pair_i = 1'b0;
    last_i = 1'b0; aligned_count_i = '0; out_ready_i = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed rows under reset configuration.
    dir_rows.push_back('{mk(0, 0, 0, 1, 0), 1, 0});              // count zero
    dir_rows.push_back('{mk(0, 0, 0, 1, 1), 1, 13107});          // marker only
    dir_rows.push_back('{mk(0, 0, 1, 1, 1), 1, 26214});          // zero mean
    dir_rows.push_back('{mk(0, 0, 0, 1, 1024), 1, 13421568});
    dir_rows.push_back('{mk(0, 0, 0, 1, 2047), 1, 13421568});    // count saturates
    dir_rows.push_back('{mk(65535, 65535, 1, 1, 1), 1, 13107});  // far pair
    dir_rows.push_back('{mk(6400, 6400, 1, 1, 1), 0, 0});        // s at far limit
    dir_rows.push_back('{mk(6401, 6400, 1, 1, 1), 1, 13107});
    dir_rows.push_back('{mk(640, 700, 1, 0, 0), 0, 0});
    dir_rows.push_back('{mk(1, 0, 1, 0, 0), 0, 0});
    dir_rows.push_back('{mk(0, 12800, 1, 1, 5), 0, 0});
    foreach (dir_rows[i]) begin
      send_pair(dir_rows[i].p, dir_rows[i].known, dir_rows[i].score);
    end

    // Extreme configurations and every filter mode.
    set_config(16'd0, 16'd0, 1'b0, 16'd0, ModeFirst);            // horizon zero
    send_pair(mk(100, 200, 1, 1, 3), 1, 0);
    set_config(16'hFFFF, 16'd1, 1'b1, 16'hFFFF, 2'd3);           // mode three
    send_pair(mk(0, 0, 1, 0, 0), 0, 0);
    send_pair(mk(1, 1, 1, 1, 1024), 0, 0);
    for (int m = 0; m < 4; m++) begin
      set_config(16'd40000, 16'd700, 1'b1, 16'd500, m[1:0]);
      send_pair(mk(400, 600, 1, 0, 0), 0, 0);
      send_pair(mk(600, 400, 1, 0, 0), 0, 0);
      send_pair(mk(300, 350, 1, 0, 0), 0, 0);
      send_pair(mk(900, 700, 1, 1, 10), 0, 0);
    end

    // Random alignments over several settings.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(16'd13107, 16'd1280, 1'b0, 16'd0, ModeFirst);
        1: set_config(16'hFFFF, 16'hFFFF, 1'b1, 16'd1200, ModeEither);
        2: set_config(16'd0, 16'd1, 1'b1, 16'd3000, ModeBoth);
        default: set_config(16'($urandom()), 16'($urandom_range(65535, 1)),
                            1'($urandom_range(1)), 16'($urandom()),
                            2'($urandom_range(3)));
      endcase
      no_idle = (ph == 2);
      for (int k = 0; k < 66; k++) begin
        pair_t p;
        p = rand_pair(($urandom_range(5) == 0) || k == 65);
        send_pair(p, 0, 0);
        // Hold the sender once until every score has drained.
        if (ph == 3 && k == 30) begin
          hold_in = 1;
          while (score_q.size() != 0) @(negedge clk_i);
          hold_in = 0;
        end
      end
    end
    no_idle = 0;

    while (score_q.size() != 0) @(negedge clk_i);
    repeat (600) @(negedge clk_i);
    $display("Run covered %0d scores from directed and random alignments,", n_scores);
    $display("all filter modes and register extremes, in %0d cycles.", cycles);
    if (errors == 0 && score_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
